@@ hdl/assert_macros.svh @@
// Assertion macros used by the module that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/rpdm_pkg.sv @@
// Types, constants and register codes of the RC pulse to drive mapper.
package rpdm_pkg;

    localparam int CAPTURE_BITS_DEFAULT = 16;
    localparam int FIELD_BITS           = 16;
    localparam int CFG_INDEX_BITS       = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_CAPTURE_PERIOD,
        REG_STEER_MIN,
        REG_STEER_MAX,
        REG_THROTTLE_FULL_FORWARD,
        REG_THROTTLE_FULL_REVERSE,
        REG_DEAD_ZONE_LOW,
        REG_DEAD_ZONE_HIGH,
        REG_THROTTLE_CENTER
    } cfg_reg_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] capture_period;
        logic [FIELD_BITS-1:0] steer_min;
        logic [FIELD_BITS-1:0] steer_max;
        logic [FIELD_BITS-1:0] throttle_full_forward;
        logic [FIELD_BITS-1:0] throttle_full_reverse;
        logic [FIELD_BITS-1:0] dead_zone_low;
        logic [FIELD_BITS-1:0] dead_zone_high;
        logic [FIELD_BITS-1:0] throttle_center;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        capture_period:        16'd16000,
        steer_min:             16'd1000,
        steer_max:             16'd2000,
        throttle_full_forward: 16'd1860,
        throttle_full_reverse: 16'd860,
        dead_zone_low:         16'd1200,
        dead_zone_high:        16'd1600,
        throttle_center:       16'd1360
    };

    typedef struct packed {
        logic [FIELD_BITS-1:0] steer;
        logic [FIELD_BITS-1:0] throttle;
        logic [FIELD_BITS-1:0] mode;
    } widths_t;

    // Mode window, exclusive on both ends.
    localparam logic [FIELD_BITS-1:0] MODE_LOW  = 16'd700;
    localparam logic [FIELD_BITS-1:0] MODE_HIGH = 16'd1300;

    localparam logic signed [FIELD_BITS:0] FULL_DRIVE = 17'sd300;
    localparam logic [7:0] FWD_LIMIT = 8'd255;
    localparam logic [8:0] REV_LIMIT = 9'd511;

    // Smallest drive for which seven tenths exceeds the forward limit.
    localparam logic [FIELD_BITS:0] FWD_SAT_DRIVE = 17'd366;

    // x / 10 equals (x * RECIP_TEN) >> RECIP_SHIFT for x below 43690.
    localparam logic [15:0] RECIP_TEN   = 16'd52429;
    localparam int          RECIP_SHIFT = 19;

endpackage

@@ hdl/rpdm_if.sv @@
// Valid/ready channel interfaces for the pulse items and the drive results.
interface rpdm_in_if;
    logic        valid;
    logic        ready;
    logic        steer_fresh;
    logic [15:0] steer_lead;
    logic [15:0] steer_trail;
    logic        throttle_fresh;
    logic [15:0] throttle_lead;
    logic [15:0] throttle_trail;
    logic        mode_fresh;
    logic [15:0] mode_lead;
    logic [15:0] mode_trail;

    modport source (
        output valid, steer_fresh, steer_lead, steer_trail,
               throttle_fresh, throttle_lead, throttle_trail,
               mode_fresh, mode_lead, mode_trail,
        input  ready
    );
    modport sink (
        input  valid, steer_fresh, steer_lead, steer_trail,
               throttle_fresh, throttle_lead, throttle_trail,
               mode_fresh, mode_lead, mode_trail,
        output ready
    );
endinterface

interface rpdm_out_if;
    logic        valid;
    logic        ready;
    logic        remote_mode;
    logic [15:0] steering_duty;
    logic [7:0]  forward_duty;
    logic [8:0]  reverse_duty;

    modport source (
        output valid, remote_mode, steering_duty, forward_duty, reverse_duty,
        input  ready
    );
    modport sink (
        input  valid, remote_mode, steering_duty, forward_duty, reverse_duty,
        output ready
    );
endinterface

@@ hdl/rpdm_capture_stage.sv @@
// First stage: turns capture times into pulse widths and holds the last widths.
module rpdm_capture_stage
    import rpdm_pkg::*;
#(
    parameter int CAPTURE_BITS = CAPTURE_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [FIELD_BITS-1:0] capture_period,
    input  logic                  take,
    rpdm_in_if.sink               pulses,
    output logic                  valid,
    output widths_t               widths
);

    // Only the low capture bits of the time fields are significant.
    localparam int CW = (CAPTURE_BITS < FIELD_BITS) ? CAPTURE_BITS : FIELD_BITS;

    logic    valid_reg;
    logic    valid_next;
    widths_t widths_reg;
    widths_t widths_next;
    logic    accept;

    function automatic logic [FIELD_BITS-1:0] pulse_width(
        input logic [CW-1:0]         lead,
        input logic [CW-1:0]         trail,
        input logic [FIELD_BITS-1:0] period
    );
        logic [CW-1:0]         back;
        logic [FIELD_BITS-1:0] back_ext;
        logic [FIELD_BITS-1:0] result;
        back     = lead - trail;
        back_ext = FIELD_BITS'(back);
        if (lead > trail)
        begin
            // The counter wrapped between the leading and the trailing edge.
            result = (back_ext > period) ? '0 : period - back_ext;
        end
        else
        begin
            result = FIELD_BITS'(trail - lead);
        end
        return result;
    endfunction

    assign pulses.ready = !valid_reg || take;
    assign accept       = pulses.valid && pulses.ready;

    always_comb
    begin
        widths_next = widths_reg;
        valid_next  = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            if (pulses.steer_fresh)
                widths_next.steer = pulse_width(pulses.steer_lead[CW-1:0],
                                                pulses.steer_trail[CW-1:0], capture_period);
            if (pulses.throttle_fresh)
                widths_next.throttle = pulse_width(pulses.throttle_lead[CW-1:0],
                                                   pulses.throttle_trail[CW-1:0],
                                                   capture_period);
            if (pulses.mode_fresh)
                widths_next.mode = pulse_width(pulses.mode_lead[CW-1:0],
                                               pulses.mode_trail[CW-1:0], capture_period);
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            widths_reg <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            widths_reg <= widths_next;
        end
    end

    assign valid  = valid_reg;
    assign widths = widths_reg;

endmodule

@@ hdl/rpdm_drive_stage.sv @@
// Second stage: clamps steering, maps throttle to drive duties, holds the result.
module rpdm_drive_stage
    import rpdm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    valid,
    input  widths_t widths,
    output logic    take,
    rpdm_out_if.source drive
);

    logic                    valid_reg, valid_next;
    logic                    remote_reg, remote_next;
    logic [FIELD_BITS-1:0]   steer_reg, steer_next;
    logic [7:0]              fwd_reg, fwd_next;
    logic [8:0]              rev_reg, rev_next;

    logic                    load;
    logic                    remote;
    logic [FIELD_BITS-1:0]   steer_clamped;
    logic signed [FIELD_BITS:0] diff;
    logic signed [FIELD_BITS:0] half;
    logic signed [FIELD_BITS:0] drive_m;
    logic [FIELD_BITS:0]     drive_mag;
    logic [11:0]             seven_m;
    logic [27:0]             tenth_prod;
    logic [7:0]              fwd_calc;
    logic [8:0]              rev_calc;

    assign take = !valid_reg || drive.ready;
    assign load = valid && take;

    assign remote = (widths.mode < MODE_HIGH) && (widths.mode > MODE_LOW);

    always_comb
    begin
        if (widths.steer > cfg.steer_max)
            steer_clamped = cfg.steer_max;
        else if (widths.steer < cfg.steer_min)
            steer_clamped = cfg.steer_min;
        else
            steer_clamped = widths.steer;
    end

    // Halving rounds toward zero, so odd negative differences are bumped first.
    assign diff = $signed({1'b0, widths.throttle}) - $signed({1'b0, cfg.throttle_center});
    assign half = (diff + $signed({{FIELD_BITS{1'b0}}, diff[FIELD_BITS]})) >>> 1;

    always_comb
    begin
        if (widths.throttle > cfg.throttle_full_forward)
            drive_m = FULL_DRIVE;
        else if (widths.throttle < cfg.throttle_full_reverse)
            drive_m = -FULL_DRIVE;
        else if (widths.throttle >= cfg.dead_zone_low && widths.throttle <= cfg.dead_zone_high)
            drive_m = '0;
        else
            drive_m = half;
    end

    assign drive_mag  = drive_m[FIELD_BITS] ? (~drive_m + 1'b1) : drive_m;
    assign seven_m    = 12'(drive_mag[8:0]) * 12'd7;
    assign tenth_prod = 28'(seven_m) * 28'(RECIP_TEN);

    always_comb
    begin
        if (drive_m[FIELD_BITS])
            fwd_calc = '0;
        else if (drive_mag >= FWD_SAT_DRIVE)
            fwd_calc = FWD_LIMIT;
        else
            fwd_calc = tenth_prod[RECIP_SHIFT+7:RECIP_SHIFT];

        if (!drive_m[FIELD_BITS])
            rev_calc = '0;
        else if (drive_mag > 17'(REV_LIMIT))
            rev_calc = REV_LIMIT;
        else
            rev_calc = drive_mag[8:0];
    end

    always_comb
    begin
        valid_next  = valid_reg;
        remote_next = remote_reg;
        steer_next  = steer_reg;
        fwd_next    = fwd_reg;
        rev_next    = rev_reg;
        if (load)
        begin
            valid_next  = 1'b1;
            remote_next = remote;
            if (remote)
            begin
                steer_next = steer_clamped;
                fwd_next   = fwd_calc;
                rev_next   = rev_calc;
            end
        end
        else if (drive.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            remote_reg <= 1'b0;
            steer_reg  <= '0;
            fwd_reg    <= '0;
            rev_reg    <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            remote_reg <= remote_next;
            steer_reg  <= steer_next;
            fwd_reg    <= fwd_next;
            rev_reg    <= rev_next;
        end
    end

    assign drive.valid         = valid_reg;
    assign drive.remote_mode   = remote_reg;
    assign drive.steering_duty = steer_reg;
    assign drive.forward_duty  = fwd_reg;
    assign drive.reverse_duty  = rev_reg;

endmodule

@@ hdl/rc_pulse_to_drive_mapper_core.sv @@
// Top level of the RC pulse to drive mapper: configuration registers and the two stages.
// The block takes one item per clock cycle, sustained, while the drive channel is ready.
// The accepting edge loads the pulse width registers; once the drive stage can take the
// item, an edge loads the output register with the steering and drive duties, and the
// result is then offered on the drive channel. Each stage holds its item while the next
// one is stalled, so a new item is still accepted whenever the width stage is empty or
// moving on. Configuration writes take effect at the edge where cfg_we is high; the
// duties hold their last values while the mode pulse is outside the remote window.
`include "assert_macros.svh"

module rc_pulse_to_drive_mapper_core
    import rpdm_pkg::*;
#(
    parameter int CAPTURE_BITS = CAPTURE_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [FIELD_BITS-1:0]     cfg_data,
    rpdm_in_if.sink                   pulses,
    rpdm_out_if.source                drive
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    stage_valid;
    logic    stage_take;
    widths_t widths;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CAPTURE_PERIOD:        cfg_next.capture_period        = cfg_data;
                REG_STEER_MIN:             cfg_next.steer_min             = cfg_data;
                REG_STEER_MAX:             cfg_next.steer_max             = cfg_data;
                REG_THROTTLE_FULL_FORWARD: cfg_next.throttle_full_forward = cfg_data;
                REG_THROTTLE_FULL_REVERSE: cfg_next.throttle_full_reverse = cfg_data;
                REG_DEAD_ZONE_LOW:         cfg_next.dead_zone_low         = cfg_data;
                REG_DEAD_ZONE_HIGH:        cfg_next.dead_zone_high        = cfg_data;
                REG_THROTTLE_CENTER:       cfg_next.throttle_center       = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    rpdm_capture_stage #(
        .CAPTURE_BITS (CAPTURE_BITS)
    ) u_capture (
        .clk            (clk),
        .rst_n          (rst_n),
        .capture_period (cfg_reg.capture_period),
        .take           (stage_take),
        .pulses         (pulses),
        .valid          (stage_valid),
        .widths         (widths)
    );

    rpdm_drive_stage u_drive (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .valid  (stage_valid),
        .widths (widths),
        .take   (stage_take),
        .drive  (drive)
    );

    // An accepted item always occupies the width stage on the next cycle.
    `ASSERT_NEXT(a_accept_fills_stage, clk, rst_n, pulses.valid && pulses.ready, stage_valid, "accepted item did not reach the width stage")

    // An item moving out of the width stage always shows up as a result.
    `ASSERT_NEXT(a_stage_to_output, clk, rst_n, stage_valid && stage_take, drive.valid, "width stage item was lost before the output")

    // Forward and reverse drive are never both active.
    `ASSERT_IMPL(a_one_direction, clk, rst_n, drive.valid, (drive.forward_duty == 8'd0) || (drive.reverse_duty == 9'd0), "forward and reverse duty both nonzero")

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the RC pulse to drive mapper core.
module tb;
    import rpdm_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int SQUEEZE_CYCLES  = 200;

    // Slightly shifted thresholds, all registers written.
    localparam cfg_t CFG_SHIFTED = '{
        capture_period:        16'd20000,
        steer_min:             16'd1100,
        steer_max:             16'd1900,
        throttle_full_forward: 16'd1800,
        throttle_full_reverse: 16'd900,
        dead_zone_low:         16'd1300,
        dead_zone_high:        16'd1500,
        throttle_center:       16'd1400
    };

    // Widest settings: no clamp, no full drive, empty dead zone, forward saturates.
    localparam cfg_t CFG_OPEN = '{
        capture_period:        16'd65535,
        steer_min:             16'd0,
        steer_max:             16'd65535,
        throttle_full_forward: 16'd65535,
        throttle_full_reverse: 16'd0,
        dead_zone_low:         16'd65535,
        dead_zone_high:        16'd0,
        throttle_center:       16'd0
    };

    // Crossed steer limits, a one-count period and a center that drives reverse saturation.
    localparam cfg_t CFG_CROSSED = '{
        capture_period:        16'd1,
        steer_min:             16'd3000,
        steer_max:             16'd1000,
        throttle_full_forward: 16'd65535,
        throttle_full_reverse: 16'd0,
        dead_zone_low:         16'd1,
        dead_zone_high:        16'd0,
        throttle_center:       16'd65535
    };

    typedef struct packed {
        logic        steer_fresh;
        logic [15:0] steer_lead;
        logic [15:0] steer_trail;
        logic        throttle_fresh;
        logic [15:0] throttle_lead;
        logic [15:0] throttle_trail;
        logic        mode_fresh;
        logic [15:0] mode_lead;
        logic [15:0] mode_trail;
    } tick_t;

    typedef struct packed {
        logic        remote_mode;
        logic [15:0] steering_duty;
        logic [7:0]  forward_duty;
        logic [8:0]  reverse_duty;
    } duty_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [FIELD_BITS-1:0]     cfg_data;

    rpdm_in_if  pulses();
    rpdm_out_if drive();

    rc_pulse_to_drive_mapper_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pulses    (pulses),
        .drive     (drive)
    );

    always #6 clk = ~clk;

    // Mirror of the block's registers and state.
    cfg_t        regs;
    logic [15:0] steer_w, throttle_w, mode_w, steer_hold;
    logic [7:0]  fwd_hold;
    logic [8:0]  rev_hold;

    tick_t tick_queue[$];
    duty_t duty_queue[$];
    tick_t bus_tick;
    duty_t want;

    int  errors_seen = 0;
    int  send_gap    = 0;
    int  stall_left  = 0;
    int  hold_left   = 0;
    int  idle_cycles = 0;
    bit  steady      = 1'b0;
    bit  squeeze_req = 1'b0;
    bit  squeezed    = 1'b0;

    function automatic logic [15:0] width_of(logic [15:0] lead, logic [15:0] trail);
        logic [15:0] back;
        if (lead > trail) begin
            back = lead - trail;
            return (back > regs.capture_period) ? 16'd0 : regs.capture_period - back;
        end
        return trail - lead;
    endfunction

    function automatic int drive_level(logic [15:0] w);
        int d;
        if (w > regs.throttle_full_forward)
            return int'(FULL_DRIVE);
        if (w < regs.throttle_full_reverse)
            return -int'(FULL_DRIVE);
        if (w >= regs.dead_zone_low && w <= regs.dead_zone_high)
            return 0;
        d = int'(w) - int'(regs.throttle_center);
        return d / 2;
    endfunction

    function automatic duty_t next_duty(tick_t t);
        duty_t       r;
        logic [15:0] steer;
        int          m;
        int          f;
        if (t.steer_fresh)
            steer_w = width_of(t.steer_lead, t.steer_trail);
        if (t.throttle_fresh)
            throttle_w = width_of(t.throttle_lead, t.throttle_trail);
        if (t.mode_fresh)
            mode_w = width_of(t.mode_lead, t.mode_trail);

        // With crossed limits, widths above the upper limit take it and all others the lower one.
        steer = steer_w;
        if (steer > regs.steer_max)
            steer = regs.steer_max;
        else if (steer < regs.steer_min)
            steer = regs.steer_min;

        m = drive_level(throttle_w);
        r.remote_mode = (mode_w < MODE_HIGH) && (mode_w > MODE_LOW);
        if (r.remote_mode) begin
            steer_hold = steer;
            if (m >= 0) begin
                f = (m * 7) / 10;
                fwd_hold = (f > int'(FWD_LIMIT)) ? FWD_LIMIT : f[7:0];
                rev_hold = '0;
            end
            else begin
                f = -m;
                fwd_hold = '0;
                rev_hold = (f > int'(REV_LIMIT)) ? REV_LIMIT : f[8:0];
            end
        end
        r.steering_duty = steer_hold;
        r.forward_duty  = fwd_hold;
        r.reverse_duty  = rev_hold;
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        if (steady)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 65)
            return 0;
        if (p < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Capture times giving width w; for w below the period they may wrap, half of the time.
    function automatic logic [31:0] span(int w);
        int lead;
        if (w < int'(regs.capture_period) && $urandom_range(0, 1) == 1) begin
            lead = $urandom_range(0, int'(regs.capture_period) - 1);
            return {16'(lead), 16'((lead + w) % int'(regs.capture_period))};
        end
        lead = $urandom_range(0, 65535 - w);
        return {16'(lead), 16'(lead + w)};
    endfunction

    function automatic tick_t tk(bit sf, int sw, bit tf, int tw, bit mf, int mw);
        tick_t t;
        t.steer_fresh    = sf;
        t.throttle_fresh = tf;
        t.mode_fresh     = mf;
        {t.steer_lead, t.steer_trail}       = span(sw);
        {t.throttle_lead, t.throttle_trail} = span(tw);
        {t.mode_lead, t.mode_trail}         = span(mw);
        return t;
    endfunction

    function automatic int near(int v);
        v = v + int'($urandom_range(0, 2)) - 1;
        if (v < 0)
            return 0;
        if (v > 65535)
            return 65535;
        return v;
    endfunction

    function automatic int steer_pick();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60)
            return $urandom_range(0, 3000);
        if (p < 80)
            return near(($urandom_range(0, 1) == 1) ? int'(regs.steer_min) : int'(regs.steer_max));
        return $urandom_range(0, 65535);
    endfunction

    function automatic int throttle_pick();
        int p;
        int thr;
        p = $urandom_range(0, 99);
        if (p < 55)
            return $urandom_range(700, 2100);
        if (p < 80) begin
            case ($urandom_range(0, 4))
                0:       thr = regs.throttle_full_forward;
                1:       thr = regs.throttle_full_reverse;
                2:       thr = regs.dead_zone_low;
                3:       thr = regs.dead_zone_high;
                default: thr = regs.throttle_center;
            endcase
            return near(thr);
        end
        return $urandom_range(0, 65535);
    endfunction

    function automatic int mode_pick();
        int p;
        p = $urandom_range(0, 99);
        if (p < 78)
            return $urandom_range(int'(MODE_LOW) + 1, int'(MODE_HIGH) - 1);
        if (p < 84)
            return near(($urandom_range(0, 1) == 1) ? int'(MODE_LOW) : int'(MODE_HIGH));
        if (p < 92)
            return $urandom_range(0, 3000);
        return $urandom_range(0, 65535);
    endfunction

    function automatic tick_t random_tick();
        logic [127:0] raw;
        if ($urandom_range(0, 99) < 85)
            return tk($urandom_range(0, 99) < 80, steer_pick(),
                      $urandom_range(0, 99) < 80, throttle_pick(),
                      $urandom_range(0, 99) < 85, mode_pick());
        raw = {$urandom, $urandom, $urandom, $urandom};
        return raw[$bits(tick_t)-1:0];
    endfunction

    // Writes every register, one per cycle, while the block is idle.
    task automatic program_regs(cfg_t c);
        cfg_reg_t    r;
        logic [15:0] v;
        r = r.first();
        do begin
            case (r)
                REG_CAPTURE_PERIOD:        v = c.capture_period;
                REG_STEER_MIN:             v = c.steer_min;
                REG_STEER_MAX:             v = c.steer_max;
                REG_THROTTLE_FULL_FORWARD: v = c.throttle_full_forward;
                REG_THROTTLE_FULL_REVERSE: v = c.throttle_full_reverse;
                REG_DEAD_ZONE_LOW:         v = c.dead_zone_low;
                REG_DEAD_ZONE_HIGH:        v = c.dead_zone_high;
                default:                   v = c.throttle_center;
            endcase
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= r;
            cfg_data  <= v;
            r = r.next();
        end while (r != r.first());
        @(posedge clk);
        cfg_we <= 1'b0;
        regs = c;
    endtask

    // Sampled at the falling edge so that all updates of the rising edge have settled.
    task automatic drain();
        do
            @(negedge clk);
        while (tick_queue.size() != 0 || pulses.valid || duty_queue.size() != 0);
    endtask

    task automatic run_random(int n);
        repeat (n)
            tick_queue.push_back(random_tick());
        drain();
    endtask

    // Sender: an item stays on the channel until it is taken.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pulses.valid <= 1'b0;
            send_gap = 0;
        end
        else begin
            if (pulses.valid && pulses.ready) begin
                bus_tick = '{pulses.steer_fresh, pulses.steer_lead, pulses.steer_trail,
                             pulses.throttle_fresh, pulses.throttle_lead, pulses.throttle_trail,
                             pulses.mode_fresh, pulses.mode_lead, pulses.mode_trail};
                duty_queue.push_back(next_duty(bus_tick));
                send_gap = pick_gap();
            end
            if (!pulses.valid || pulses.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    pulses.valid <= 1'b0;
                end
                else if (tick_queue.size() > 0) begin
                    bus_tick = tick_queue.pop_front();
                    pulses.steer_fresh    <= bus_tick.steer_fresh;
                    pulses.steer_lead     <= bus_tick.steer_lead;
                    pulses.steer_trail    <= bus_tick.steer_trail;
                    pulses.throttle_fresh <= bus_tick.throttle_fresh;
                    pulses.throttle_lead  <= bus_tick.throttle_lead;
                    pulses.throttle_trail <= bus_tick.throttle_trail;
                    pulses.mode_fresh     <= bus_tick.mode_fresh;
                    pulses.mode_lead      <= bus_tick.mode_lead;
                    pulses.mode_trail     <= bus_tick.mode_trail;
                    pulses.valid          <= 1'b1;
                end
                else begin
                    pulses.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result and stalls at random.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            drive.ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end
        else begin
            if (drive.valid && drive.ready) begin
                if (duty_queue.size() == 0) begin
                    $error("drive result with nothing expected");
                    errors_seen++;
                end
                else begin
                    want = duty_queue.pop_front();
                    if (drive.remote_mode !== want.remote_mode) begin
                        $error("remote_mode: expected %0d, got %0d",
                               want.remote_mode, drive.remote_mode);
                        errors_seen++;
                    end
                    if (drive.steering_duty !== want.steering_duty) begin
                        $error("steering_duty: expected %0d, got %0d",
                               want.steering_duty, drive.steering_duty);
                        errors_seen++;
                    end
                    if (drive.forward_duty !== want.forward_duty) begin
                        $error("forward_duty: expected %0d, got %0d",
                               want.forward_duty, drive.forward_duty);
                        errors_seen++;
                    end
                    if (drive.reverse_duty !== want.reverse_duty) begin
                        $error("reverse_duty: expected %0d, got %0d",
                               want.reverse_duty, drive.reverse_duty);
                        errors_seen++;
                    end
                end
            end
            if (squeeze_req && !squeezed) begin
                squeezed  = 1'b1;
                hold_left = SQUEEZE_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                drive.ready <= 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left--;
                drive.ready <= 1'b0;
            end
            else begin
                drive.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((pulses.valid && pulses.ready) || (drive.valid && drive.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        pulses.valid = 1'b0;
        pulses.steer_fresh    = 1'b0;
        pulses.steer_lead     = '0;
        pulses.steer_trail    = '0;
        pulses.throttle_fresh = 1'b0;
        pulses.throttle_lead  = '0;
        pulses.throttle_trail = '0;
        pulses.mode_fresh     = 1'b0;
        pulses.mode_lead      = '0;
        pulses.mode_trail     = '0;
        drive.ready  = 1'b0;
        regs       = CFG_RESET;
        steer_w    = '0;
        throttle_w = '0;
        mode_w     = '0;
        steer_hold = '0;
        fwd_hold   = '0;
        rev_hold   = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items under the reset settings.
        tick_queue.push_back(tk(0, 0, 0, 0, 0, 0));           // nothing captured yet
        tick_queue.push_back(tk(1, 1500, 1, 1500, 1, 700));   // mode on the lower edge
        tick_queue.push_back(tk(0, 0, 0, 0, 1, 1300));        // mode on the upper edge
        tick_queue.push_back(tk(1, 500, 1, 2000, 1, 701));    // remote, steer clamped up
        tick_queue.push_back(tk(1, 2500, 1, 800, 0, 0));      // steer clamped down, full reverse
        tick_queue.push_back(tk(0, 0, 1, 1199, 1, 1299));     // odd negative halving
        tick_queue.push_back(tk(0, 0, 1, 1200, 0, 0));
        tick_queue.push_back(tk(0, 0, 1, 1600, 0, 0));
        tick_queue.push_back(tk(0, 0, 1, 1601, 0, 0));
        tick_queue.push_back(tk(1, 1000, 1, 1860, 0, 0));
        tick_queue.push_back(tk(1, 2000, 1, 1861, 0, 0));
        tick_queue.push_back(tk(1, 1001, 1, 860, 0, 0));
        tick_queue.push_back(tk(1, 1999, 1, 859, 0, 0));
        tick_queue.push_back(tk(1, 1700, 1, 1000, 1, 1500)); // out of the window, duties hold
        // Edges that wrapped around the counter period.
        tick_queue.push_back('{1'b1, 16'd15990, 16'd1490, 1'b1, 16'd15000, 16'd1000,
                               1'b1, 16'd15900, 16'd900});
        // Lead too far past the trail or equal to it: the widths of this item collapse to zero.
        tick_queue.push_back('{1'b1, 16'd65535, 16'd65535, 1'b1, 16'd65535, 16'd0,
                               1'b1, 16'd65535, 16'd0});
        tick_queue.push_back('{1'b1, 16'd0, 16'd0, 1'b0, 16'd0, 16'd65535,
                               1'b1, 16'd0, 16'd1000});
        tick_queue.push_back('{1'b1, 16'd0, 16'd65535, 1'b1, 16'd0, 16'd65535,
                               1'b0, 16'd65535, 16'd65535});
        tick_queue.push_back(tk(1, 1500, 1, 1500, 1, 1000));
        drain();

        program_regs(CFG_SHIFTED);
        run_random(200);

        program_regs(CFG_OPEN);
        run_random(120);

        steady = 1'b1;
        program_regs(CFG_CROSSED);
        run_random(120);
        steady = 1'b0;

        // The receiver holds off while the sender keeps offering items.
        program_regs(CFG_RESET);
        squeeze_req = 1'b1;
        run_random(260);

        repeat (8) @(posedge clk);
        if (errors_seen == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

@@ rc_pulse_to_drive_mapper_core.f @@
+incdir+hdl
hdl/rpdm_pkg.sv
hdl/rpdm_if.sv
hdl/rpdm_capture_stage.sv
hdl/rpdm_drive_stage.sv
hdl/rc_pulse_to_drive_mapper_core.sv
bench/tb.sv
